// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the checker file grg_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/grg_pkg.sv =====
// ----------------------------------------------------------------------------
// grg_pkg
// Shared types and constants for the gamma ramp generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package grg_pkg;

  localparam int IDX_W   = 8;
  localparam int GAMMA_W = 10;
  localparam int WORD_W  = 16;
  localparam int CFG_W   = 10;
  localparam int FRAC_W  = 20;
  localparam int LOG_W   = FRAC_W + 3;

  // configuration register indexes
  localparam logic CFG_GAMMA_Q8     = 1'b0;
  localparam logic CFG_LEGACY_CLAMP = 1'b1;

  localparam logic [GAMMA_W-1:0] GAMMA_ONE   = 10'd256;
  localparam logic [GAMMA_W-1:0] GAMMA_MIN   = 10'd128;
  localparam logic [GAMMA_W-1:0] GAMMA_MAX   = 10'd768;

  localparam int LOG_ROUNDS = FRAC_W;  // squaring rounds of the log
  localparam int DIV_STEPS  = 31;      // quotient bits of d*256/gamma
  localparam int SQ_STEPS   = 31;      // result bits of one square root
  localparam int EXP_ROUNDS = FRAC_W;  // square roots per entry

  // log2(v) in Q3.20, same squaring scheme as the datapath
  function automatic logic [LOG_W-1:0] log2_fix_const(input logic [7:0] v);
    logic [63:0]      m;
    logic [LOG_W-1:0] r;
    int               e;
    e = 0;
    for (int j = 0; j < 8; j++) begin
      if (v[j]) e = j;
    end
    m = 64'(v) << (30 - e);
    r = LOG_W'(e) << FRAC_W;
    for (int k = 0; k < FRAC_W; k++) begin
      m = (m * m) >> 30;
      if (m >= 64'h0000_0000_8000_0000) begin
        m = m >> 1;
        r[FRAC_W-1-k] = 1'b1;
      end
    end
    return r;
  endfunction

  localparam logic [LOG_W-1:0] LOG2_MAX = log2_fix_const(8'd255);

  typedef struct packed {
    logic               start;
    logic [IDX_W-1:0]   index;
    logic [GAMMA_W-1:0] gamma;
  } pwr_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] level;
  } pwr_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/grg_power_unit.sv =====
// ----------------------------------------------------------------------------
// grg_power_unit
// Iterative 255*(i/255)^(1/gamma) using log2, divide and a square-root chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grg_power_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  grg_pkg::pwr_req_t  req,
  output grg_pkg::pwr_rsp_t  rsp
);
  import grg_pkg::*;

  typedef enum logic [2:0] {
    P_IDLE, P_LOG, P_DIV_INIT, P_DIV, P_SQ_INIT, P_SQ, P_SHIFT, P_SCALE
  } pstate_t;

  pstate_t      state_r;
  logic [4:0]   cnt_r;
  logic [4:0]   round_r;
  logic [30:0]  m_r;
  logic [2:0]   e_r;
  logic [19:0]  lfrac_r;
  logic [30:0]  dvd_r;
  logic [9:0]   rem_r;
  logic [9:0]   q_r;
  logic [61:0]  x_r;
  logic [61:0]  res_r;
  logic [61:0]  bit_r;
  logic [19:0]  tf_r;
  logic [10:0]  ti_r;
  logic [30:0]  y_r;
  logic [7:0]   level_r;
  logic         done_r;

  logic [2:0]       msb_e;
  logic [61:0]      prod;
  logic [31:0]      sq;
  logic [10:0]      div_trial;
  logic [62:0]      sub_a;
  logic [62:0]      sub_b;
  logic [62:0]      sub_d;
  logic             sub_ge;
  logic [61:0]      res_nxt;
  logic [LOG_W-1:0] li;
  logic [LOG_W-1:0] dlog;
  logic [30:0]      quot_nxt;
  logic [30:0]      y_half;
  logic [38:0]      scaled;
  logic [8:0]       level9;

  always_comb begin
    msb_e = 3'd0;
    for (int j = 0; j < 8; j++) begin
      if (req.index[j]) msb_e = 3'(j);
    end
  end

  assign prod = {31'b0, m_r} * {31'b0, m_r};
  assign sq   = prod[61:30];

  assign div_trial = {rem_r, dvd_r[30]};

  // one subtract/compare shared by the divider and the square root
  always_comb begin
    if (state_r == P_DIV) begin
      sub_a = 63'(div_trial);
      sub_b = 63'(q_r);
    end else begin
      sub_a = {1'b0, x_r};
      sub_b = {1'b0, res_r} + {1'b0, bit_r};
    end
  end
  assign sub_d  = sub_a - sub_b;
  assign sub_ge = ~sub_d[62];

  assign res_nxt  = sub_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);
  assign quot_nxt = {dvd_r[29:0], sub_ge};

  assign li   = {e_r, lfrac_r};
  assign dlog = (LOG2_MAX > li) ? (LOG2_MAX - li) : '0;

  assign y_half = tf_r[0] ? (y_r >> 1) : y_r;

  assign scaled = {y_r, 8'b0} - {8'b0, y_r} + (39'd1 << 29);
  assign level9 = scaled[38:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        P_IDLE: begin
          if (req.start) begin
            q_r <= req.gamma;
            if (req.gamma == GAMMA_ONE) begin
              level_r <= req.index;
              done_r  <= 1'b1;
            end else if (req.index == '0) begin
              level_r <= 8'd0;
              done_r  <= 1'b1;
            end else begin
              e_r     <= msb_e;
              m_r     <= {23'b0, req.index} << (5'd30 - {2'b0, msb_e});
              lfrac_r <= '0;
              cnt_r   <= '0;
              state_r <= P_LOG;
            end
          end
        end
        P_LOG: begin
          m_r     <= sq[31] ? sq[31:1] : sq[30:0];
          lfrac_r <= {lfrac_r[18:0], sq[31]};
          cnt_r   <= cnt_r + 5'd1;
          if (cnt_r == 5'(LOG_ROUNDS - 1)) state_r <= P_DIV_INIT;
        end
        P_DIV_INIT: begin
          dvd_r   <= {dlog, 8'b0};
          rem_r   <= '0;
          cnt_r   <= '0;
          state_r <= P_DIV;
        end
        P_DIV: begin
          rem_r <= sub_ge ? sub_d[9:0] : div_trial[9:0];
          dvd_r <= quot_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(DIV_STEPS - 1)) begin
            tf_r    <= quot_nxt[19:0];
            ti_r    <= quot_nxt[30:20];
            y_r     <= 31'd1 << 30;
            round_r <= '0;
            state_r <= P_SQ_INIT;
          end
        end
        P_SQ_INIT: begin
          // y <<= 30 after the optional halving for this bit of tf
          x_r     <= {1'b0, y_half, 30'b0};
          res_r   <= '0;
          bit_r   <= 62'd1 << 60;
          cnt_r   <= '0;
          state_r <= P_SQ;
        end
        P_SQ: begin
          if (sub_ge) x_r <= sub_d[61:0];
          res_r <= res_nxt;
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(SQ_STEPS - 1)) begin
            y_r     <= res_nxt[30:0];
            tf_r    <= tf_r >> 1;
            round_r <= round_r + 5'd1;
            state_r <= (round_r == 5'(EXP_ROUNDS - 1)) ? P_SHIFT : P_SQ_INIT;
          end
        end
        P_SHIFT: begin
          y_r     <= (ti_r >= 11'd31) ? '0 : (y_r >> ti_r[4:0]);
          state_r <= P_SCALE;
        end
        P_SCALE: begin
          level_r <= (level9 > 9'd255) ? 8'd255 : level9[7:0];
          done_r  <= 1'b1;
          state_r <= P_IDLE;
        end
        default: state_r <= P_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.level = level_r;

endmodule

`default_nettype wire

// ===== rtl/core/gamma_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// gamma_ramp_generator
// One 16-bit display gamma ramp word per index, with legacy clamp and
// monotonic enforcement.
// ----------------------------------------------------------------------------
//  channel | ports                                 | direction
//  --------+---------------------------------------+----------
//  cfg     | cfg_we, cfg_index, cfg_wdata          | in
//  in      | in_valid/in_ready, in_ramp_index      | in
//  out     | out_valid/out_ready, out_ramp_entry,  | out
//          | out_is_last                           |
//
//  Identity gamma or index 0: the power unit answers straight from idle.
//  Other entries pass through 20 log squarings, a 31-step divide and
//  twenty square-root rounds; divide and square root share one subtractor.
//  One request in flight; the next is taken while a result waits in the
//  output register. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gamma_ramp_generator #(
  parameter int RAMP_SIZE = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [grg_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [grg_pkg::IDX_W-1:0]    in_ramp_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [grg_pkg::WORD_W-1:0]   out_ramp_entry,
  output logic                         out_is_last
);
  import grg_pkg::*;

  localparam int CMP_W = ($clog2(RAMP_SIZE) > IDX_W) ? $clog2(RAMP_SIZE) : IDX_W;
  localparam logic [CMP_W-1:0] LAST_IDX = CMP_W'(RAMP_SIZE - 1);

  typedef enum logic [1:0] {S_IDLE, S_START, S_WAIT, S_POST} state_t;

  state_t              state_r;
  logic [GAMMA_W-1:0]  gamma_r;
  logic                clamp_r;
  logic [IDX_W-1:0]    idx_r;
  logic [7:0]          level_r;
  logic [WORD_W-1:0]   prev_r;
  logic                out_valid_r;
  logic [WORD_W-1:0]   out_entry_r;
  logic                out_last_r;

  logic [GAMMA_W-1:0]  gamma_eff;
  logic [WORD_W-1:0]   word_raw;
  logic [WORD_W-1:0]   ceil_word;
  logic [WORD_W-1:0]   word_clamp;
  logic [WORD_W-1:0]   word_mono;
  logic                idx_last;
  logic                out_load;
  pwr_req_t            pwr_req;
  pwr_rsp_t            pwr_rsp;

  assign gamma_eff = (gamma_r < GAMMA_MIN) ? GAMMA_MIN :
                     (gamma_r > GAMMA_MAX) ? GAMMA_MAX : gamma_r;

  assign pwr_req.start = (state_r == S_START);
  assign pwr_req.index = idx_r;
  assign pwr_req.gamma = gamma_eff;

  grg_power_unit u_power (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (pwr_req),
    .rsp   (pwr_rsp)
  );

  // lower half ceiling is (128+i)<<8, tightened to 254<<8 at index 127
  assign word_raw   = {level_r, level_r};
  assign ceil_word  = (idx_r == 8'd127) ? {8'd254, 8'd0} : {1'b1, idx_r[6:0], 8'd0};
  assign word_clamp = (clamp_r && !idx_r[7] && (word_raw > ceil_word)) ? ceil_word : word_raw;
  assign word_mono  = ((idx_r != '0) && (word_clamp < prev_r)) ? prev_r : word_clamp;
  assign idx_last   = (CMP_W'(idx_r) == LAST_IDX);

  assign out_load = (state_r == S_POST) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gamma_r     <= GAMMA_ONE;
      clamp_r     <= 1'b0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GAMMA_Q8:     gamma_r <= cfg_wdata[GAMMA_W-1:0];
          CFG_LEGACY_CLAMP: clamp_r <= cfg_wdata[0];
          default:          gamma_r <= gamma_r;
        endcase
      end

      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            idx_r   <= in_ramp_index;
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_WAIT;
        S_WAIT: begin
          if (pwr_rsp.done) begin
            level_r <= pwr_rsp.level;
            state_r <= S_POST;
          end
        end
        S_POST: begin
          if (out_load) begin
            out_entry_r <= word_mono;
            out_last_r  <= idx_last;
            out_valid_r <= 1'b1;
            prev_r      <= word_mono;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_ramp_entry = out_entry_r;
  assign out_is_last    = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/core/grg_checker.sv =====
// ----------------------------------------------------------------------------
// grg_checker
// Port-level checks of the gamma ramp generator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module grg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_ramp_entry,
  input logic        out_is_last
);

  logic        out_stall;
  logic        in_take;
  logic [17:0] out_bus;

  assign out_stall = out_valid && !out_ready;
  assign in_take   = in_valid && in_ready;
  assign out_bus   = {out_valid, out_ramp_entry, out_is_last};

  // a stalled result holds its payload
  `ASSERT_CLK(a_out_hold, clk, !rst_n, out_stall |=> $stable(out_bus), "stalled result changed")

  // one request at a time
  `ASSERT_CLK(a_one_in_flight, clk, !rst_n, in_take |=> !in_ready, "request taken while busy")

  // a result never appears the cycle right after a request
  `ASSERT_CLK(a_min_latency, clk, !rst_n, in_take |=> !$rose(out_valid), "result too early")

  // once the result is posted the input side reopens
  `ASSERT_CLK(a_ready_on_result, clk, !rst_n, $rose(out_valid) |-> in_ready, "not ready")

  `ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> !out_valid && in_ready, "bad reset state")

endmodule

bind gamma_ramp_generator grg_checker u_grg_checker (.*);

`default_nettype wire
